// File: hw/rtl/mbx_pkg.sv
// Shared types and constants for the dual CPU nibble mailbox.
// No dependencies; used by the interfaces, mbx_state and the top level.
package mbx_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned NIB_W  = 4;

  typedef logic [NIB_W-1:0] nib_t;

  // Bus access codes carried by the operation field
  typedef enum logic [OP_W-1:0] {
    OP_MAIN_PORT_WR = 3'd0,
    OP_MAIN_COMM_WR = 3'd1,
    OP_MAIN_COMM_RD = 3'd2,
    OP_SUB_PORT_WR  = 3'd3,
    OP_SUB_COMM_WR  = 3'd4,
    OP_SUB_COMM_RD  = 3'd5
  } op_t;

  // Mode pointer values above the slot range
  localparam nib_t MODE_STATUS  = 4'd4;
  localparam nib_t MODE_NMI_OFF = 4'd5;
  localparam nib_t MODE_NMI_ON  = 4'd6;

  // Full flag bits: toward sound at 0/1, toward main at 2/3 (upper index bit)
  localparam logic DIR_TO_SOUND = 1'b0;
  localparam logic DIR_TO_MAIN  = 1'b1;

  // One registered bus access
  typedef struct packed {
    op_t  op;
    nib_t nib;
  } req_t;

  // One result item
  typedef struct packed {
    nib_t read_data;
    logic nmi_pulse;
    logic sound_reset_pulse;
  } result_t;

endpackage

// File: hw/rtl/mbx_if.sv
// Valid/ready channel interfaces for the mailbox access and result streams.
// Depends on mbx_pkg for field widths.
interface mbx_access_if;
  logic                           valid;
  logic                           ready;
  logic [mbx_pkg::OP_W-1:0]       operation;
  logic [mbx_pkg::DATA_W-1:0]     bus_data;

  modport source (output valid, operation, bus_data, input ready);
  modport sink (input valid, operation, bus_data, output ready);
endinterface

interface mbx_result_if;
  logic                           valid;
  logic                           ready;
  logic [mbx_pkg::NIB_W-1:0]      read_data;
  logic                           nmi_pulse;
  logic                           sound_reset_pulse;

  modport source (output valid, read_data, nmi_pulse, sound_reset_pulse, input ready);
  modport sink (input valid, read_data, nmi_pulse, sound_reset_pulse, output ready);
endinterface

// File: hw/rtl/mbx_state.sv
// Mailbox state (slots, pointers, flags, NMI control) and the per-access logic.
// Depends on mbx_pkg. The result is combinational from the registered request.
module mbx_state (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  mbx_pkg::req_t    req,
  output mbx_pkg::result_t res
);

  mbx_pkg::nib_t ts_slots [4];
  mbx_pkg::nib_t tm_slots [4];
  mbx_pkg::nib_t main_ptr;
  mbx_pkg::nib_t sound_ptr;
  logic [3:0]    full_flags;
  logic          nmi_en;
  logic          nmi_pend;

  mbx_pkg::nib_t ts_slots_next [4];
  mbx_pkg::nib_t tm_slots_next [4];
  mbx_pkg::nib_t main_ptr_next;
  mbx_pkg::nib_t sound_ptr_next;
  logic [3:0]    full_flags_next;
  logic          nmi_en_next;
  logic          nmi_pend_next;
  logic          clear_all;

  logic          main_in_slots;
  logic          sound_in_slots;

  assign main_in_slots  = (main_ptr[3:2] == 2'b00);
  assign sound_in_slots = (sound_ptr[3:2] == 2'b00);

  // Next state and result for the access in the request register
  always_comb begin
    ts_slots_next   = ts_slots;
    tm_slots_next   = tm_slots;
    main_ptr_next   = main_ptr;
    sound_ptr_next  = sound_ptr;
    full_flags_next = full_flags;
    nmi_en_next     = nmi_en;
    nmi_pend_next   = nmi_pend;
    clear_all       = 1'b0;
    res             = '0;
    case (req.op)
      mbx_pkg::OP_MAIN_PORT_WR: begin
        main_ptr_next = req.nib;
      end
      mbx_pkg::OP_MAIN_COMM_WR: begin
        if (main_in_slots) begin
          ts_slots_next[main_ptr[1:0]] = req.nib;
          main_ptr_next = main_ptr + 4'd1;
          // odd slot closes a pair: mark full, raise NMI or leave it pending
          if (main_ptr[0]) begin
            full_flags_next[{mbx_pkg::DIR_TO_SOUND, main_ptr[1]}] = 1'b1;
            nmi_pend_next = 1'b1;
            if (nmi_en) begin
              nmi_pend_next = 1'b0;
              res.nmi_pulse = 1'b1;
            end
          end
        end else if (main_ptr == mbx_pkg::MODE_STATUS && req.nib != '0) begin
          clear_all             = 1'b1;
          res.sound_reset_pulse = 1'b1;
        end
      end
      mbx_pkg::OP_MAIN_COMM_RD: begin
        if (main_in_slots) begin
          res.read_data = tm_slots[main_ptr[1:0]];
          main_ptr_next = main_ptr + 4'd1;
          if (main_ptr[0]) begin
            full_flags_next[{mbx_pkg::DIR_TO_MAIN, main_ptr[1]}] = 1'b0;
          end
        end else if (main_ptr == mbx_pkg::MODE_STATUS) begin
          res.read_data = full_flags;
        end
      end
      mbx_pkg::OP_SUB_PORT_WR: begin
        sound_ptr_next = req.nib;
      end
      mbx_pkg::OP_SUB_COMM_WR: begin
        if (sound_in_slots) begin
          tm_slots_next[sound_ptr[1:0]] = req.nib;
          sound_ptr_next = sound_ptr + 4'd1;
          if (sound_ptr[0]) begin
            full_flags_next[{mbx_pkg::DIR_TO_MAIN, sound_ptr[1]}] = 1'b1;
          end
        end else if (sound_ptr == mbx_pkg::MODE_NMI_OFF) begin
          nmi_en_next = 1'b0;
        end else if (sound_ptr == mbx_pkg::MODE_NMI_ON) begin
          nmi_en_next = 1'b1;
        end
        // NMI check sees the enable as just written
        if (nmi_pend && nmi_en_next) begin
          nmi_pend_next = 1'b0;
          res.nmi_pulse = 1'b1;
        end
      end
      mbx_pkg::OP_SUB_COMM_RD: begin
        if (sound_in_slots) begin
          res.read_data  = ts_slots[sound_ptr[1:0]];
          sound_ptr_next = sound_ptr + 4'd1;
          if (sound_ptr[0]) begin
            full_flags_next[{mbx_pkg::DIR_TO_SOUND, sound_ptr[1]}] = 1'b0;
          end
        end else if (sound_ptr == mbx_pkg::MODE_STATUS) begin
          res.read_data = full_flags;
        end
        if (nmi_pend && nmi_en) begin
          nmi_pend_next = 1'b0;
          res.nmi_pulse = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers; a main reset request clears everything like rst
  always_ff @(posedge clk) begin
    if (rst || (fire && clear_all)) begin
      for (int i = 0; i < 4; i++) begin
        ts_slots[i] <= '0;
        tm_slots[i] <= '0;
      end
      main_ptr   <= '0;
      sound_ptr  <= '0;
      full_flags <= '0;
      nmi_en     <= 1'b0;
      nmi_pend   <= 1'b0;
    end else if (fire) begin
      ts_slots   <= ts_slots_next;
      tm_slots   <= tm_slots_next;
      main_ptr   <= main_ptr_next;
      sound_ptr  <= sound_ptr_next;
      full_flags <= full_flags_next;
      nmi_en     <= nmi_en_next;
      nmi_pend   <= nmi_pend_next;
    end
  end

endmodule

// File: hw/rtl/dual_cpu_nibble_mailbox_core.sv
// Top level of the dual CPU nibble mailbox: request register, state logic,
// result register. Depends on mbx_pkg, mbx_if.sv and mbx_state.
//
// Usage:
//   access (sink): one bus request per valid/ready handshake, carrying
//     operation (main/sub port write, comm write, comm read) and bus_data.
//   result (source): exactly one result per request, in order, carrying
//     read_data, nmi_pulse and sound_reset_pulse.
// Pipeline: two register stages, the request register and then the result
//   register; a request waits in the request register while the result stalls.
// Throughput: one request per cycle while result.ready is high; the state
//   update is a single short logic pass from request register to result register.
// Reset: rst (synchronous) clears all slots, pointers, flags and NMI state
//   and empties both registers. A main comm write of a nonzero nibble in
//   status mode clears the same state internally.
// Stall: while result.ready is low the result register holds; the request
//   register still takes one more request, then access.ready drops until
//   the result is taken.
module dual_cpu_nibble_mailbox_core (
  input  logic      clk,
  input  logic      rst,
  mbx_access_if.sink   access,
  mbx_result_if.source result
);

  logic              req_valid;
  mbx_pkg::req_t     req_q;
  logic              out_valid;
  mbx_pkg::result_t  res_q;
  mbx_pkg::result_t  res;
  logic              advance;

  // Request moves into the result register when that slot is free or leaving
  assign advance      = req_valid && (!out_valid || result.ready);
  assign access.ready = !req_valid || advance;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (access.ready) begin
      req_valid <= access.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (access.ready && access.valid) begin
      req_q.op  <= mbx_pkg::op_t'(access.operation);
      req_q.nib <= access.bus_data[mbx_pkg::NIB_W-1:0];
    end
  end

  mbx_state u_state (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .req  (req_q),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign result.valid             = out_valid;
  assign result.read_data         = res_q.read_data;
  assign result.nmi_pulse         = res_q.nmi_pulse;
  assign result.sound_reset_pulse = res_q.sound_reset_pulse;

  // A sound reset and an NMI come from separate branches, so they never come together
  a_rst_no_nmi: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.sound_reset_pulse && result.nmi_pulse))
    else $error("sound reset and NMI in one result");

  // Only a main comm write can reset the sound CPU
  a_rst_source: assert property (@(posedge clk) disable iff (rst)
    (advance && res.sound_reset_pulse) |-> (req_q.op == mbx_pkg::OP_MAIN_COMM_WR))
    else $error("sound reset from wrong access");

  // Writes return zero data
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && req_q.op != mbx_pkg::OP_MAIN_COMM_RD
             && req_q.op != mbx_pkg::OP_SUB_COMM_RD) |-> (res.read_data == '0))
    else $error("nonzero read data on a write");

  // NMI only from comm writes or sub reads
  a_nmi_source: assert property (@(posedge clk) disable iff (rst)
    (advance && res.nmi_pulse) |->
      (req_q.op == mbx_pkg::OP_MAIN_COMM_WR || req_q.op == mbx_pkg::OP_SUB_COMM_WR ||
       req_q.op == mbx_pkg::OP_SUB_COMM_RD))
    else $error("NMI from wrong access");

endmodule
